@@ hdl/hdmkc_pkg.sv @@
// ----------------------------------------------------------------------------
// hdmkc_pkg
// Shared constants and types for the hashed key cache.
// ----------------------------------------------------------------------------
`default_nettype none
package hdmkc_pkg;
    localparam int SLOTS = 32;
    localparam int KEY_MAX = 128;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int KEY_W = $clog2(KEY_MAX);
    localparam int LEN_W = KEY_W + 1;
    localparam int KMEM_W = SLOT_W + KEY_W;
    localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_PUT    = 2'd1;
    localparam logic [1:0] CMD_INVAL  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic       absorb;    // hash step on hash_reg with in_byte
        logic       load_vol;  // start key: load the volume id for hashing
        logic       vol_step;  // one volume byte hash step
        logic       append;    // write in_byte into key buffer
        logic       cmp_start; // begin stored-key compare or copy
        logic       cmp_step;  // advance compare
        logic       commit_put;
        logic       copy_step; // copy one byte into slot key store
        logic       end_key;
        logic       inval;
    } ctrl_t;

    typedef struct packed {
        logic       vol_done;
        logic       cmp_done;
        logic       copy_done;
        logic       overflow;
        logic       is_zero;
    } stat_t;
endpackage
`default_nettype wire

@@ hdl/hashed_direct_mapped_key_cache.sv @@
// ----------------------------------------------------------------------------
// hashed_direct_mapped_key_cache
// FNV-1a style hashed direct-mapped cache of found flags and entries per key.
// ----------------------------------------------------------------------------
// channel | direction | fields
// s_      | in        | cmd, volume_id, key_byte, put_found, put_entry
// m_      | out       | kind, hit, found, entry_out, stored
// A key byte is accepted, then hashed and written to the key buffer; the
// first byte of a key is preceded by hashing the volume id byte by byte.
// After a terminator is taken the result follows a compare with the slot's
// stored key for a lookup, a copy into it for a put, or neither for an
// overlong put; compare or copy walks the slot key memory one byte a cycle.
// Reset is synchronous; a pending result blocks new requests until taken.
`default_nettype none
module hashed_direct_mapped_key_cache
    import hdmkc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [63:0] s_volume_id,
    input  wire logic [7:0]  s_key_byte,
    input  wire logic        s_put_found,
    input  wire logic [63:0] s_put_entry,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic             m_hit,
    output logic             m_found,
    output logic [63:0]      m_entry_out,
    output logic             m_stored
);
    ctrl_t c;
    stat_t st;
    logic  kind, latch, hit, fnd, sto;
    logic [63:0] ent;
    logic  fire;

    assign fire = s_valid && s_ready && (s_cmd == CMD_LOOKUP || s_cmd == CMD_PUT);

    hdmkc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_key_byte,
        .stat(st), .ctrl(c), .m_valid, .m_ready, .out_kind(kind),
        .res_latch(latch)
    );

    // hold the accepted request's payload while it is processed
    logic [7:0]  byte_q;
    logic        pf_q;
    logic [63:0] pe_q;
    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_q <= s_key_byte;
            pf_q   <= s_put_found;
            pe_q   <= s_put_entry;
        end
    end

    hdmkc_datapath u_dp (
        .aclk, .aresetn, .ctrl(c), .stat(st),
        .in_volume(s_volume_id),
        .in_byte(byte_q),
        .in_found(pf_q),
        .in_entry(pe_q),
        .res_hit(hit), .res_found(fnd), .res_entry(ent), .res_stored(sto)
    );

    always_ff @(posedge aclk) begin
        if (latch) begin
            m_kind      <= kind;
            m_hit       <= kind ? 1'b0 : hit;
            m_found     <= kind ? 1'b0 : fnd;
            m_entry_out <= kind ? 64'd0 : ent;
            m_stored    <= kind ? sto : 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ hdl/hdmkc_datapath.sv @@
// ----------------------------------------------------------------------------
// hdmkc_datapath
// Hash register, key buffer, slot tables and stored-key compare.
// ----------------------------------------------------------------------------
`default_nettype none
module hdmkc_datapath
    import hdmkc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctrl_t       ctrl,
    output stat_t            stat,
    input  wire logic [63:0] in_volume,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_found,
    input  wire logic [63:0] in_entry,
    output logic             res_hit,
    output logic             res_found,
    output logic [63:0]      res_entry,
    output logic             res_stored
);
    logic [63:0] hash_reg, hash_next, mul_in;
    logic [63:0] vol_reg, vol_sh_reg;
    logic [3:0]  vcnt_reg;
    logic [63:0] gen_reg;
    logic [LEN_W-1:0] len_reg;
    logic        ovf_reg;
    logic [7:0]  kbuf [KEY_MAX];
    logic [7:0]  kmem [SLOTS*KEY_MAX];
    logic [SLOTS-1:0] valid_reg, sfound_reg;
    logic [63:0] sgen [SLOTS];
    logic [63:0] svol [SLOTS];
    logic [63:0] sent [SLOTS];
    logic [SLOT_W-1:0] slot_reg;
    logic [LEN_W-1:0]  idx_reg, idx_prev;
    logic [7:0]  kbuf_q, kmem_q;
    logic        rd_ok_reg, wr_ok_reg, match_reg;

    assign mul_in = ctrl.vol_step ? (hash_reg ^ {56'd0, vol_sh_reg[7:0]})
                                  : (hash_reg ^ {56'd0, in_byte});
    // FNV prime is 2^40 + 0x1b3: multiply as shifts and adds
    assign hash_next = (mul_in << 40) + (mul_in << 8) + (mul_in << 7) + (mul_in << 5)
                     + (mul_in << 4) + (mul_in << 1) + mul_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= HASH_BASIS;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            gen_reg   <= 64'd1;
            valid_reg <= '0;
            vcnt_reg  <= '0;
            vol_reg   <= '0;
        end else begin
            if (ctrl.inval) begin
                gen_reg <= (gen_reg == '1) ? 64'd1 : gen_reg + 64'd1;
            end
            if (ctrl.load_vol) begin
                vol_reg    <= in_volume;
                vol_sh_reg <= in_volume;
                vcnt_reg   <= '0;
            end
            if (ctrl.vol_step) begin
                hash_reg   <= hash_next;
                vol_sh_reg <= vol_sh_reg >> 8;
                vcnt_reg   <= vcnt_reg + 4'd1;
            end
            if (ctrl.absorb) begin
                hash_reg <= hash_next;
            end
            if (ctrl.append) begin
                if (len_reg < LEN_W'(KEY_MAX - 1)) begin
                    len_reg <= len_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (ctrl.commit_put && !ovf_reg) begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (ctrl.end_key) begin
                hash_reg <= HASH_BASIS;
                len_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.append && len_reg < LEN_W'(KEY_MAX - 1)) begin
            kbuf[len_reg[KEY_W-1:0]] <= in_byte;
        end
    end

    assign idx_prev = idx_reg - 1'b1;

    // stored-key compare and copy: one byte per cycle, registered reads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ok_reg <= 1'b0;
            wr_ok_reg <= 1'b0;
        end else begin
            rd_ok_reg <= ctrl.cmp_step;
            wr_ok_reg <= ctrl.copy_step;
        end
        if (ctrl.cmp_start) begin
            slot_reg  <= hash_reg[SLOT_W-1:0];
            idx_reg   <= '0;
            match_reg <= 1'b1;
        end
        if (ctrl.cmp_step || ctrl.copy_step) begin
            idx_reg <= idx_reg + 1'b1;
        end
        kbuf_q <= kbuf[idx_reg[KEY_W-1:0]];
        kmem_q <= kmem[{slot_reg, idx_reg[KEY_W-1:0]}];
        // compare up to and including the terminator position
        if (rd_ok_reg && idx_prev <= len_reg) begin
            if (kmem_q != ((idx_prev == len_reg) ? 8'd0 : kbuf_q)) begin
                match_reg <= 1'b0;
            end
        end
        if (wr_ok_reg) begin
            kmem[{slot_reg, idx_prev[KEY_W-1:0]}] <=
                (idx_prev == len_reg) ? 8'd0 : kbuf_q;
        end
        if (ctrl.commit_put && !ovf_reg) begin
            sgen[slot_reg]       <= gen_reg;
            svol[slot_reg]       <= vol_reg;
            sfound_reg[slot_reg] <= in_found;
            if (in_found) begin
                sent[slot_reg] <= in_entry;
            end
        end
    end

    logic meta_hold_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.cmp_start) begin
            meta_hold_reg <= valid_reg[hash_reg[SLOT_W-1:0]];
        end
    end

    assign stat.vol_done  = (vcnt_reg == 4'd8);
    // cmp_done waits until the compare of the terminator position has settled in match_reg
    assign stat.cmp_done  = (idx_reg == len_reg + 2'd2) && rd_ok_reg;
    assign stat.copy_done = (idx_reg == len_reg + 1'b1) && wr_ok_reg;
    assign stat.overflow  = ovf_reg;
    assign stat.is_zero   = (len_reg == '0) && !ovf_reg;

    logic hit;
    assign hit = !ovf_reg && meta_hold_reg && match_reg &&
                 (sgen[slot_reg] == gen_reg) && (svol[slot_reg] == vol_reg);
    assign res_hit    = hit;
    assign res_found  = hit && sfound_reg[slot_reg];
    assign res_entry  = (hit && sfound_reg[slot_reg]) ? sent[slot_reg] : 64'd0;
    assign res_stored = !ovf_reg;
endmodule
`default_nettype wire

@@ hdl/hdmkc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hdmkc_ctrl
// Sequencer: hashes volume and bytes, runs compare or store at the terminator.
// ----------------------------------------------------------------------------
`default_nettype none
module hdmkc_ctrl
    import hdmkc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    input  wire logic [7:0] s_key_byte,
    input  wire stat_t      stat,
    output ctrl_t           ctrl,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            out_kind,
    output logic            res_latch
);
    localparam logic [2:0] S_IDLE = 3'd0, S_VOL = 3'd1, S_BYTE = 3'd2,
                           S_CMP = 3'd3, S_COPY = 3'd4, S_RES = 3'd5;
    logic [2:0] state_reg, state_next;
    logic       term_reg, kind_reg, mv_reg;
    logic       fire;

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign fire = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign out_kind = kind_reg;

    always_comb begin
        ctrl = '0;
        state_next = state_reg;
        res_latch = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (fire) begin
                    if (s_cmd == CMD_INVAL) begin
                        ctrl.inval = 1'b1;
                    end else if (s_cmd != CMD_NONE) begin
                        ctrl.load_vol = stat.is_zero;
                        state_next = stat.is_zero ? S_VOL : S_BYTE;
                    end
                end
            end
            S_VOL: begin
                if (stat.vol_done) begin
                    state_next = S_BYTE;
                end else begin
                    ctrl.vol_step = 1'b1;
                end
            end
            S_BYTE: begin
                if (!term_reg) begin
                    ctrl.absorb = 1'b1;
                    ctrl.append = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    ctrl.cmp_start = 1'b1;
                    state_next = kind_reg ? S_COPY : S_CMP;
                end
            end
            S_CMP: begin
                ctrl.cmp_step = !stat.cmp_done;
                if (stat.cmp_done) begin
                    res_latch = 1'b1;
                    state_next = S_RES;
                end
            end
            S_COPY: begin
                if (stat.overflow || stat.copy_done) begin
                    ctrl.commit_put = 1'b1;
                    res_latch = 1'b1;
                    state_next = S_RES;
                end else begin
                    ctrl.copy_step = 1'b1;
                end
            end
            S_RES: begin
                ctrl.end_key = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            term_reg  <= 1'b0;
            kind_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                term_reg <= (s_key_byte == 8'd0);
                kind_reg <= (s_cmd == CMD_PUT);
            end
            if (state_reg == S_RES) begin
                mv_reg <= 1'b1;
            end else if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/hdmkc_checker.sv @@
// ----------------------------------------------------------------------------
// hdmkc_checker
// Port-level checks on the cache's request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
module hdmkc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_kind,
    input wire logic m_hit,
    input wire logic m_stored
);
    a_mvalid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken with result pending");
    a_put_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> !m_hit) else $error("put reports hit");
    a_lookup_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> !m_stored) else $error("lookup reports stored");
endmodule
bind hashed_direct_mapped_key_cache hdmkc_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_kind, .m_hit, .m_stored
);
`default_nettype wire
